// File: design/timestamped_packet_ring_index_defines.svh
// Assertion macros used by the timestamped packet ring index engine (tpri_back).
`ifndef TIMESTAMPED_PACKET_RING_INDEX_DEFINES_SVH
`define TIMESTAMPED_PACKET_RING_INDEX_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define TPRI_ASSERT_NOW(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |-> (cond)) else $error(msg);

// Check a condition in the cycle after its trigger.
`define TPRI_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (cond)) else $error(msg);

`endif

// File: design/tpri_pkg.sv
// Types and constants of the timestamped packet ring index.
package tpri_pkg;

    localparam int INDEX_DEPTH = 64;
    localparam int IDX_W       = 6;
    localparam int CNT_W       = 7;
    localparam int MAX_OUT     = 64;

    typedef enum logic [1:0] {
        ACT_WRITE  = 2'd0,
        ACT_QUERY  = 2'd1,
        ACT_LOOKUP = 2'd2
    } t_action;

    localparam logic [1:0] CFG_BUFFER_BYTES   = 2'd0;
    localparam logic [1:0] CFG_EXTRADATA_CODE = 2'd1;

    typedef enum logic [3:0] {
        S_IDLE, S_WR, S_WFIN, S_QA, S_QB, S_QEND, S_LA, S_LB, S_FAIL
    } t_state;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] size;
        logic [32:0] total;
        logic [63:0] pts;
        logic [63:0] start;
        logic [2:0]  kind;
        logic [5:0]  idx;
    } t_cmd;

    typedef struct packed {
        logic [31:0] offset;
        logic [63:0] stamp;
        logic [2:0]  kind;
        logic [32:0] length;
        logic [31:0] gen;
    } t_slot;

    typedef struct packed {
        logic        status;
        logic [31:0] offset;
        logic [63:0] pts;
        logic [2:0]  kind;
        logic [31:0] payload;
        logic [6:0]  count;
        logic [63:0] oldest;
        logic [63:0] latest;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [31:0] buffer_bytes;
        logic [2:0]  extradata_code;
    } t_cfg;

endpackage

// File: design/tpri_front.sv
// Input queue that precomputes write length and query start for each word.
module tpri_front import tpri_pkg::*; #(
    parameter int HEADER_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_payload_size,
    input  logic [63:0] i_pts,
    input  logic [2:0]  i_packet_type,
    input  logic [63:0] i_duration,
    input  logic [5:0]  i_entry_index,
    output logic        o_cmd_valid,
    output t_cmd        o_cmd,
    input  logic        i_cmd_take
);
    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_in, w_out;

    always_comb begin
        w_cmd.action = i_action;
        w_cmd.size   = i_payload_size;
        w_cmd.total  = 33'(HEADER_BYTES) + {1'b0, i_payload_size};
        w_cmd.pts    = i_pts;
        w_cmd.start  = i_pts - i_duration;
        w_cmd.kind   = i_packet_type;
        w_cmd.idx    = i_entry_index;
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_in        = i_push && !o_full;
    assign w_out       = i_cmd_take && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_in) r_wp <= !r_wp;
            if (w_out) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_in} - {1'b0, w_out};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in) r_q[r_wp] <= w_cmd;
    end
endmodule

// File: design/tpri_back.sv
// Ring index engine: slot memory, ring state, query walk and result register.
module tpri_back import tpri_pkg::*; #(
    parameter int HEADER_BYTES = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_cmd_take,
    output logic    o_res_valid,
    output t_result o_res,
    input  logic    i_res_pop
);
    `include "timestamped_packet_ring_index_defines.svh"

    t_slot          r_mem [INDEX_DEPTH];
    t_slot          r_rd;
    t_state         r_state, n_state;
    t_cmd           r_cmd, n_cmd;
    logic [IDX_W-1:0] r_addr, n_addr, r_head, n_head;
    logic [CNT_W-1:0] r_count, n_count, r_i, n_i, r_n, n_n;
    logic [31:0]    r_woff, n_woff, r_goff, n_goff, r_gen, n_gen;
    logic [63:0]    r_oldest, n_oldest, r_latest, n_latest;
    logic           r_wfull, n_wfull;
    t_result        r_pend, n_pend;
    logic           r_pend_v, n_pend_v;
    t_result        r_out;
    logic           r_out_v;
    logic           w_can, w_emit, w_mwr;
    t_result        w_eres;
    t_slot          w_wslot;
    logic           w_match;
    logic [IDX_W-1:0] w_oldest_slot;
    logic [33:0]    w_end;
    logic           w_wrap;
    logic           w_qbusy;

    function automatic t_result mk_fail(logic [CNT_W-1:0] c, logic [63:0] o,
                                        logic [63:0] l);
        t_result res;
        res        = '0;
        res.status = 1'b1;
        res.count  = c;
        res.oldest = o;
        res.latest = l;
        res.last   = 1'b1;
        return res;
    endfunction

    function automatic t_result mk_slot(t_slot s, logic [CNT_W-1:0] c, logic [63:0] o,
                                        logic [63:0] l, logic lst);
        t_result res;
        logic [32:0] pl;
        pl          = s.length - 33'(HEADER_BYTES);
        res.status  = 1'b0;
        res.offset  = s.offset;
        res.pts     = s.stamp;
        res.kind    = s.kind;
        res.payload = pl[31:0];
        res.count   = c;
        res.oldest  = o;
        res.latest  = l;
        res.last    = lst;
        return res;
    endfunction

    assign w_can         = !r_out_v || i_res_pop;
    assign w_oldest_slot = r_head - r_count[IDX_W-1:0];
    assign o_res_valid   = r_out_v;
    assign o_res         = r_out;
    assign w_end         = {2'b0, r_goff} + {1'b0, r_cmd.total};
    assign w_wrap        = (w_end > {2'b0, i_cfg.buffer_bytes});
    assign w_match       = (r_rd.gen == r_gen)
                         && ($signed(r_cmd.start) <= $signed(r_rd.stamp))
                         && ($signed(r_rd.stamp) <= $signed(r_cmd.pts))
                         && (r_rd.kind != i_cfg.extradata_code);
    assign w_qbusy       = (r_state == S_QA) || (r_state == S_QB) || (r_state == S_QEND);

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_addr     = r_addr;
        n_head     = r_head;
        n_count    = r_count;
        n_i        = r_i;
        n_n        = r_n;
        n_woff     = r_woff;
        n_goff     = r_goff;
        n_gen      = r_gen;
        n_oldest   = r_oldest;
        n_latest   = r_latest;
        n_wfull    = r_wfull;
        n_pend     = r_pend;
        n_pend_v   = r_pend_v;
        o_cmd_take = 1'b0;
        w_emit     = 1'b0;
        w_eres     = mk_fail(r_count, r_oldest, r_latest);
        w_mwr      = 1'b0;
        w_wslot    = '0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_take = 1'b1;
                    n_cmd      = i_cmd;
                    case (t_action'(i_cmd.action))
                        ACT_WRITE: begin
                            n_addr  = r_head + 1'b1;
                            n_state = (i_cmd.total > {1'b0, i_cfg.buffer_bytes})
                                    ? S_FAIL : S_WR;
                        end
                        ACT_QUERY: begin
                            n_addr  = w_oldest_slot;
                            n_i     = '0;
                            n_n     = '0;
                            n_state = (r_count == '0) ? S_FAIL : S_QA;
                        end
                        ACT_LOOKUP: begin
                            n_addr  = w_oldest_slot + i_cmd.idx;
                            n_state = ({1'b0, i_cmd.idx} >= r_count) ? S_FAIL : S_LA;
                        end
                        default: n_state = S_FAIL;
                    endcase
                end
            end
            S_WR: begin
                n_woff         = w_wrap ? 32'd0 : r_goff;
                n_gen          = r_gen + {31'd0, w_wrap};
                w_mwr          = 1'b1;
                w_wslot.offset = n_woff;
                w_wslot.stamp  = r_cmd.pts;
                w_wslot.kind   = r_cmd.kind;
                w_wslot.length = r_cmd.total;
                w_wslot.gen    = n_gen;
                n_goff         = n_woff + r_cmd.total[31:0];
                n_head         = r_head + 1'b1;
                n_wfull        = (r_count == CNT_W'(INDEX_DEPTH));
                if (!n_wfull) begin
                    n_count = r_count + 1'b1;
                    if (r_count == '0) n_oldest = r_cmd.pts;
                end
                n_latest = r_cmd.pts;
                n_state  = S_WFIN;
            end
            S_WFIN: begin
                if (w_can) begin
                    if (r_wfull) n_oldest = r_rd.stamp;
                    w_emit         = 1'b1;
                    w_eres         = '0;
                    w_eres.offset  = r_woff;
                    w_eres.pts     = r_cmd.pts;
                    w_eres.kind    = r_cmd.kind;
                    w_eres.payload = r_cmd.size;
                    w_eres.count   = r_count;
                    w_eres.oldest  = n_oldest;
                    w_eres.latest  = r_latest;
                    w_eres.last    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_QA: n_state = S_QB;
            S_QB: begin
                if (!(w_match && r_pend_v && !w_can)) begin
                    if (w_match) begin
                        if (r_pend_v) begin
                            w_emit = 1'b1;
                            w_eres = r_pend;
                        end
                        n_pend   = mk_slot(r_rd, r_count, r_oldest, r_latest, 1'b0);
                        n_pend_v = 1'b1;
                        n_n      = r_n + 1'b1;
                    end
                    if ((r_i + 1'b1 == r_count)
                        || (w_match && r_n == CNT_W'(MAX_OUT - 1))) begin
                        n_state = S_QEND;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_addr  = r_addr + 1'b1;
                        n_state = S_QA;
                    end
                end
            end
            S_QEND: begin
                if (w_can) begin
                    w_emit = 1'b1;
                    if (r_pend_v) begin
                        w_eres      = r_pend;
                        w_eres.last = 1'b1;
                    end
                    n_pend_v = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            S_LA: n_state = S_LB;
            S_LB: begin
                if (w_can) begin
                    w_emit = 1'b1;
                    if (r_rd.gen == r_gen)
                        w_eres = mk_slot(r_rd, r_count, r_oldest, r_latest, 1'b1);
                    n_state = S_IDLE;
                end
            end
            S_FAIL: begin
                if (w_can) begin
                    w_emit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_goff   <= '0;
            r_gen    <= '0;
            r_oldest <= '0;
            r_latest <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_goff   <= n_goff;
            r_gen    <= n_gen;
            r_oldest <= n_oldest;
            r_latest <= n_latest;
            r_pend_v <= n_pend_v;
            if (w_emit) r_out_v <= 1'b1;
            else if (i_res_pop) r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_addr  <= n_addr;
        r_i     <= n_i;
        r_n     <= n_n;
        r_woff  <= n_woff;
        r_wfull <= n_wfull;
        r_pend  <= n_pend;
        if (w_emit) r_out <= w_eres;
    end

    always_ff @(posedge i_clk) begin
        if (w_mwr) r_mem[r_head] <= w_wslot;
        r_rd <= r_mem[r_addr];
    end

    `TPRI_ASSERT_NEXT(a_out_hold, r_out_v && !i_res_pop && !w_emit, r_out_v, "result lost")
    `TPRI_ASSERT_NEXT(a_wr_count, r_state == S_WR, r_count != '0, "write left ring empty")
    `TPRI_ASSERT_NOW(a_pend_state, r_pend_v, w_qbusy, "stray pending result")
    `TPRI_ASSERT_NOW(a_emit_room, w_emit, w_can, "emit over waiting result")
endmodule

// File: design/timestamped_packet_ring_index.sv
// Top level of the timestamped packet ring index: configuration and front/back engine.
//  channel | handshake              | words
//  input   | i_push / o_full        | action, payload_size, pts, packet_type, duration, index
//  result  | o_empty / i_pop        | status, entry fields, count, oldest/latest, last
//  config  | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
// A write passes S_WR and S_WFIN and a lookup S_LA and S_LB, through the registered slot read.
// A rejected write or unknown action passes S_FAIL; a range query S_QA and S_QB per held entry, then S_QEND.
// Reset is synchronous; the slot memory is not cleared.
// A full result register stalls the engine; the two-word input queue fills meanwhile.
module timestamped_packet_ring_index import tpri_pkg::*; #(
    parameter int HEADER_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_payload_size,
    input  logic [63:0] i_pts,
    input  logic [2:0]  i_packet_type,
    input  logic [63:0] i_duration,
    input  logic [5:0]  i_entry_index,
    output logic        o_empty,
    input  logic        i_pop,
    output logic        o_status,
    output logic [31:0] o_entry_offset,
    output logic [63:0] o_entry_pts,
    output logic [2:0]  o_entry_type,
    output logic [31:0] o_payload_bytes,
    output logic [6:0]  o_entry_count,
    output logic [63:0] o_oldest_pts,
    output logic [63:0] o_latest_pts,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    t_cfg    r_cfg;
    t_cmd    w_cmd;
    logic    w_cmd_valid, w_cmd_take, w_res_valid;
    t_result w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.buffer_bytes   <= 32'd1048576;
            r_cfg.extradata_code <= 3'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BUFFER_BYTES:   r_cfg.buffer_bytes   <= i_cfg_data;
                CFG_EXTRADATA_CODE: r_cfg.extradata_code <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    tpri_front #(.HEADER_BYTES(HEADER_BYTES)) u_front (
        .i_clk, .i_rst_n, .i_push, .o_full, .i_action, .i_payload_size, .i_pts,
        .i_packet_type, .i_duration, .i_entry_index,
        .o_cmd_valid(w_cmd_valid), .o_cmd(w_cmd), .i_cmd_take(w_cmd_take)
    );

    tpri_back #(.HEADER_BYTES(HEADER_BYTES)) u_back (
        .i_clk, .i_rst_n, .i_cfg(r_cfg), .i_cmd_valid(w_cmd_valid), .i_cmd(w_cmd),
        .o_cmd_take(w_cmd_take), .o_res_valid(w_res_valid), .o_res(w_res),
        .i_res_pop(i_pop)
    );

    assign o_empty         = !w_res_valid;
    assign o_status        = w_res.status;
    assign o_entry_offset  = w_res.offset;
    assign o_entry_pts     = w_res.pts;
    assign o_entry_type    = w_res.kind;
    assign o_payload_bytes = w_res.payload;
    assign o_entry_count   = w_res.count;
    assign o_oldest_pts    = w_res.oldest;
    assign o_latest_pts    = w_res.latest;
    assign o_last          = w_res.last;
endmodule
